FILE: src/ffe_pkg.sv
// ffe_pkg: shared types and constants of the farthest-future-use eviction block
// used by ffe_slots, ffe_req_store and farthest_future_use_eviction; depends on nothing
package ffe_pkg;

    localparam int DEF_MAX_REQUESTS = 128;
    localparam int DEF_MAX_SLOTS    = 16;
    localparam int DEF_ID_BITS      = 8;
    localparam int CFG_W            = 5;
    localparam int COUNT_W          = 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_PROBE,
        ST_WALK,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic probe;
        logic walk;
        logic pick;
    } slot_cmd_t;

    typedef struct packed {
        logic hit;
        logic free_ok;
        logic multi_full;
        logic multi_walk;
        logic scan_last;
    } slot_stat_t;

endpackage

FILE: src/farthest_future_use_eviction.sv
// farthest_future_use_eviction: top level with the replay sequencer
// uses ffe_pkg, ffe_req_store and ffe_slots
//
// Input beats (s_*) load a sequence of item ids, one per cycle, while s_tready
// is high; the beat with s_tlast set closes the sequence. Beats beyond
// MAX_REQUESTS are dropped but their tlast still closes the sequence.
// The block then replays the stored sequence against the configured number
// of slots (cfg_wr_data, 0 acts as 1, values above MAX_SLOTS act as
// MAX_SLOTS) and drops s_tready until the replay is done. One result beat
// (m_*) carries the eviction count, saturated at 255.
// Replay per stored request: a fetch and a probe for a hit or a fill; for an
// eviction also a walk over the future requests (one per cycle through the
// request memory read port, until one candidate is left or the sequence ends)
// and a scan of the N configured slots, one slot per cycle by the shared min-id
// comparator. The count is then handed to the output register.
// The output register lets loading of the next sequence start while the
// result waits; a stalled m_tready holds the result, and a finished replay
// waits for the register to free. Reset empties the sequence and slots,
// drops m_tvalid and sets the slot count to 1.
module farthest_future_use_eviction #(
    parameter int MAX_REQUESTS = ffe_pkg::DEF_MAX_REQUESTS,
    parameter int MAX_SLOTS    = ffe_pkg::DEF_MAX_SLOTS,
    parameter int ID_BITS      = ffe_pkg::DEF_ID_BITS,
    localparam int TDATA_W     = ((ID_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ffe_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [TDATA_W-1:0]          s_tdata,   // item_id
    input  logic                        s_tlast,   // is_last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ffe_pkg::COUNT_W-1:0] m_tdata    // eviction_count
);

    localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int LEN_W  = $clog2(MAX_REQUESTS + 1);
    localparam int NS_W   = $clog2(MAX_SLOTS + 1);
    localparam int CW     = ffe_pkg::COUNT_W;

    ffe_pkg::state_t     state_reg, state_next;
    logic [ffe_pkg::CFG_W-1:0] cfg_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ADDR_W-1:0]   i_reg, i_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic [ID_BITS-1:0]  cur_reg, cur_next;
    logic [CW-1:0]       evict_reg, evict_next;
    logic                out_valid_reg, out_valid_next;
    logic [CW-1:0]       out_data_reg, out_data_next;

    logic [NS_W-1:0]     nslots;
    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ID_BITS-1:0]  rd_data;
    logic [ID_BITS-1:0]  key;
    ffe_pkg::slot_cmd_t  cmd;
    ffe_pkg::slot_stat_t stat;
    logic                s_beat;
    logic                i_is_last;
    logic                j_more;

    always_comb begin
        if (cfg_reg == '0) begin
            nslots = NS_W'(1);
        end else if (int'(cfg_reg) > MAX_SLOTS) begin
            nslots = NS_W'(MAX_SLOTS);
        end else begin
            nslots = NS_W'(cfg_reg);
        end
    end

    assign s_tready  = (state_reg == ffe_pkg::ST_LOAD);
    assign s_beat    = s_tvalid && s_tready;
    assign wr_en     = s_beat && (len_reg < LEN_W'(MAX_REQUESTS));
    assign i_is_last = ((LEN_W'(i_reg) + LEN_W'(1)) == len_reg);
    assign j_more    = ((LEN_W'(j_reg) + LEN_W'(1)) < len_reg);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    ffe_req_store #(
        .MAX_REQUESTS(MAX_REQUESTS),
        .ID_BITS     (ID_BITS)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(len_reg[ADDR_W-1:0]),
        .wr_data(s_tdata[ID_BITS-1:0]),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    ffe_slots #(
        .MAX_SLOTS(MAX_SLOTS),
        .ID_BITS  (ID_BITS)
    ) u_slots (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .key    (key),
        .nslots (nslots),
        .stat   (stat)
    );

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        evict_next     = evict_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = i_reg;
        key            = rd_data;
        cmd            = '0;
        case (state_reg)
            ffe_pkg::ST_LOAD: begin
                if (s_beat) begin
                    if (wr_en) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    if (s_tlast) begin
                        cmd.clear  = 1'b1;
                        evict_next = '0;
                        i_next     = '0;
                        state_next = ffe_pkg::ST_FETCH;
                    end
                end
            end
            ffe_pkg::ST_FETCH: begin
                rd_en      = 1'b1;
                state_next = ffe_pkg::ST_PROBE;
            end
            ffe_pkg::ST_PROBE: begin
                cmd.probe = 1'b1;
                cur_next  = rd_data;
                if (stat.hit || stat.free_ok) begin
                    if (i_is_last) begin
                        state_next = ffe_pkg::ST_EMIT;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ffe_pkg::ST_FETCH;
                    end
                end else begin
                    if (evict_reg != '1) begin
                        evict_next = evict_reg + CW'(1);
                    end
                    if (!i_is_last && stat.multi_full) begin
                        rd_en      = 1'b1;
                        rd_addr    = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                        state_next = ffe_pkg::ST_WALK;
                    end else begin
                        state_next = ffe_pkg::ST_PICK;
                    end
                end
            end
            ffe_pkg::ST_WALK: begin
                cmd.walk = 1'b1;
                if (j_more && stat.multi_walk) begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg + 1'b1;
                    j_next  = j_reg + 1'b1;
                end else begin
                    state_next = ffe_pkg::ST_PICK;
                end
            end
            ffe_pkg::ST_PICK: begin
                cmd.pick = 1'b1;
                key      = cur_reg;
                if (stat.scan_last) begin
                    if (i_is_last) begin
                        state_next = ffe_pkg::ST_EMIT;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ffe_pkg::ST_FETCH;
                    end
                end
            end
            ffe_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = evict_reg;
                    len_next       = '0;
                    state_next     = ffe_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = ffe_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ffe_pkg::ST_LOAD;
            cfg_reg       <= ffe_pkg::CFG_W'(1);
            len_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_REQUESTS))
        else $error("request length beyond store depth");

    a_index_in_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffe_pkg::ST_FETCH || state_reg == ffe_pkg::ST_PROBE ||
         state_reg == ffe_pkg::ST_PICK) |-> (LEN_W'(i_reg) < len_reg))
        else $error("replay index past end of sequence");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ffe_pkg::ST_LOAD) |=> (evict_reg >= $past(evict_reg)))
        else $error("eviction count went down during replay");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ffe_pkg::ST_EMIT))
        else $error("result beat raised outside emit");

endmodule

FILE: src/ffe_req_store.sv
// ffe_req_store: request sequence memory, one write port and one registered read port
// uses ffe_pkg; instantiated by farthest_future_use_eviction
module ffe_req_store #(
    parameter int MAX_REQUESTS = ffe_pkg::DEF_MAX_REQUESTS,
    parameter int ID_BITS      = ffe_pkg::DEF_ID_BITS,
    localparam int ADDR_W      = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ID_BITS-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ID_BITS-1:0] rd_data
);

    logic [ID_BITS-1:0] mem [MAX_REQUESTS];
    logic [ID_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ffe_slots.sv
// ffe_slots: resident slot cells with per-slot id compare, candidate mask and
// the shared min-id compare unit that scans one slot per cycle; uses ffe_pkg
module ffe_slots #(
    parameter int MAX_SLOTS = ffe_pkg::DEF_MAX_SLOTS,
    parameter int ID_BITS   = ffe_pkg::DEF_ID_BITS,
    localparam int NS_W     = $clog2(MAX_SLOTS + 1),
    localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffe_pkg::slot_cmd_t  cmd,
    input  logic [ID_BITS-1:0]  key,
    input  logic [NS_W-1:0]     nslots,
    output ffe_pkg::slot_stat_t stat
);

    logic [ID_BITS-1:0]   slot_id_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [MAX_SLOTS-1:0] cand_reg, cand_next;
    logic [SLOT_W-1:0]    scan_reg, scan_next;
    logic [SLOT_W-1:0]    victim_reg, victim_next;
    logic [ID_BITS-1:0]   best_reg, best_next;
    logic                 found_reg, found_next;

    logic [MAX_SLOTS-1:0] active;
    logic [MAX_SLOTS-1:0] match;
    logic [MAX_SLOTS-1:0] free_vec;
    logic [MAX_SLOTS-1:0] cand_walk;
    logic [SLOT_W-1:0]    free_idx;
    logic [ID_BITS-1:0]   sel_id;
    logic                 take;
    logic [SLOT_W-1:0]    victim_sel;
    logic                 fill_en;
    logic                 evict_en;

    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            active[s] = (NS_W'(s) < nslots);
            match[s]  = valid_reg[s] && (slot_id_reg[s] == key);
        end
        free_vec = ~valid_reg & active;
        free_idx = '0;
        for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
            if (free_vec[s]) begin
                free_idx = SLOT_W'(s);
            end
        end
    end

    assign cand_walk = cand_reg & ~match;
    assign sel_id    = slot_id_reg[scan_reg];
    assign take      = cand_reg[scan_reg] && (!found_reg || (sel_id < best_reg));
    assign victim_sel = take ? scan_reg : victim_reg;

    assign stat.hit        = |match;
    assign stat.free_ok    = |free_vec;
    assign stat.multi_full = |(valid_reg & (valid_reg - 1'b1));
    assign stat.multi_walk = |(cand_walk & (cand_walk - 1'b1));
    assign stat.scan_last  = (NS_W'(scan_reg) == (nslots - NS_W'(1)));

    assign fill_en  = cmd.probe && !stat.hit && stat.free_ok;
    assign evict_en = cmd.pick && stat.scan_last;

    always_comb begin
        valid_next  = valid_reg;
        cand_next   = cand_reg;
        scan_next   = scan_reg;
        victim_next = victim_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        if (cmd.clear) begin
            valid_next = '0;
            cand_next  = '0;
        end else if (cmd.probe && !stat.hit) begin
            if (stat.free_ok) begin
                valid_next[free_idx] = 1'b1;
            end else begin
                cand_next   = valid_reg;
                scan_next   = '0;
                victim_next = '0;
                found_next  = 1'b0;
            end
        end else if (cmd.walk) begin
            cand_next = cand_walk;
        end else if (cmd.pick) begin
            scan_next = scan_reg + 1'b1;
            if (take) begin
                victim_next = scan_reg;
                best_next   = sel_id;
                found_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            cand_reg   <= '0;
            scan_reg   <= '0;
            victim_reg <= '0;
            found_reg  <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            cand_reg   <= cand_next;
            scan_reg   <= scan_next;
            victim_reg <= victim_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
        if (fill_en) begin
            slot_id_reg[free_idx] <= key;
        end else if (evict_en) begin
            slot_id_reg[victim_sel] <= key;
        end
    end

    a_cand_in_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cand_reg & ~valid_reg) == '0)
        else $error("candidate outside resident slots");

endmodule

FILE: bench/farthest_future_use_eviction_tb.sv
`timescale 1ns / 1ps
// farthest_future_use_eviction_tb: self-checking bench for the optimal-replacement eviction counter
// drives request sequences and slot settings, predicts each count in-bench; needs ffe_pkg and the dut
module farthest_future_use_eviction_tb;

    localparam int SEND_PER_PHASE = 567;

    typedef logic [7:0] id_q_t[$];

    typedef struct packed {
        bit                        wr_cfg;
        logic [ffe_pkg::CFG_W-1:0] cfg;
        logic [7:0]                id;
        bit                        last;
        int                        known;
    } stim_row_t;

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [ffe_pkg::CFG_W-1:0]    cfg_wr_data = '0;
    logic                         s_tvalid    = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata     = '0;
    logic                         s_tlast     = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready    = 1'b0;
    logic [ffe_pkg::COUNT_W-1:0]  m_tdata;

    logic [ffe_pkg::COUNT_W-1:0]  expected_evictions[$];
    logic [7:0]                   pending_requests[$];
    logic [ffe_pkg::CFG_W-1:0]    slot_setting = 5'd1;
    int                           errors = 0;
    int                           beats_sent = 0;
    int                           send_idle = 22;
    int                           recv_idle = 56;

    stim_row_t directed_rows [19] = '{
        '{1'b0, 5'd0,  8'h01, 1'b0, -1},
        '{1'b0, 5'd0,  8'h02, 1'b0, -1},
        '{1'b0, 5'd0,  8'h01, 1'b1,  2},   // reset slot count of one
        '{1'b1, 5'd0,  8'h00, 1'b0, -1},   // zero acts as one slot
        '{1'b0, 5'd0,  8'hFF, 1'b1,  1},
        '{1'b1, 5'd31, 8'hAA, 1'b1,  0},   // above max acts as max slots
        '{1'b1, 5'd2,  8'h01, 1'b0, -1},
        '{1'b0, 5'd0,  8'h02, 1'b0, -1},
        '{1'b0, 5'd0,  8'h03, 1'b0, -1},
        '{1'b0, 5'd0,  8'h01, 1'b0, -1},
        '{1'b0, 5'd0,  8'h02, 1'b1, -1},
        '{1'b0, 5'd0,  8'h09, 1'b0, -1},   // no future use: smallest id goes
        '{1'b0, 5'd0,  8'h04, 1'b0, -1},
        '{1'b0, 5'd0,  8'h07, 1'b1, -1},
        '{1'b1, 5'd3,  8'h55, 1'b0, -1},
        '{1'b0, 5'd0,  8'hAA, 1'b0, -1},
        '{1'b0, 5'd0,  8'hFF, 1'b0, -1},
        '{1'b0, 5'd0,  8'h00, 1'b0, -1},
        '{1'b0, 5'd0,  8'h55, 1'b1, -1}
    };

    farthest_future_use_eviction u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),    // item_id
        .s_tlast     (s_tlast),    // is_last
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)     // eviction_count
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [ffe_pkg::COUNT_W-1:0] belady_evictions(
            input id_q_t reqs, input logic [ffe_pkg::CFG_W-1:0] setting);
        int                                slots;
        int                                evicted;
        int                                free_slot;
        int                                victim;
        bit                                hit;
        logic [7:0]                        ids [ffe_pkg::DEF_MAX_SLOTS];
        logic [ffe_pkg::DEF_MAX_SLOTS-1:0] valid;
        logic [ffe_pkg::DEF_MAX_SLOTS-1:0] cand;
        slots   = (setting == 0) ? 1 :
                  (int'(setting) > ffe_pkg::DEF_MAX_SLOTS) ? ffe_pkg::DEF_MAX_SLOTS :
                  int'(setting);
        valid   = '0;
        evicted = 0;
        for (int i = 0; i < reqs.size(); i++) begin
            hit       = 1'b0;
            free_slot = -1;
            for (int s = 0; s < slots; s++) begin
                if (valid[s]) begin
                    if (ids[s] == reqs[i]) hit = 1'b1;
                end else if (free_slot < 0) begin
                    free_slot = s;
                end
            end
            if (hit) continue;
            if (free_slot >= 0) begin
                ids[free_slot]   = reqs[i];
                valid[free_slot] = 1'b1;
                continue;
            end
            if (evicted < 255) evicted++;
            cand = valid;
            for (int j = i + 1; j < reqs.size() && $countones(cand) > 1; j++)
                for (int s = 0; s < slots; s++)
                    if (cand[s] && ids[s] == reqs[j]) cand[s] = 1'b0;
            victim = -1;
            for (int s = 0; s < slots; s++)
                if (cand[s] && (victim < 0 || ids[s] < ids[victim])) victim = s;
            if (victim < 0) victim = 0;
            ids[victim]   = reqs[i];
            valid[victim] = 1'b1;
        end
        return evicted[ffe_pkg::COUNT_W-1:0];
    endfunction

    task automatic send_beat(input logic [7:0] id, input bit last, input int known);
        logic [ffe_pkg::COUNT_W-1:0] predicted;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (pending_requests.size() < ffe_pkg::DEF_MAX_REQUESTS) pending_requests.push_back(id);
        if (last) begin
            predicted = belady_evictions(pending_requests, slot_setting);
            expected_evictions.push_back(known >= 0 ? known[ffe_pkg::COUNT_W-1:0] : predicted);
            pending_requests.delete();
        end
    endtask

    // sender holds off until the block has drained, then writes the slot count
    task automatic write_slot_count(input logic [ffe_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_evictions.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        slot_setting  = value;
    endtask

    task automatic random_sequence();
        int         len;
        int         pool_n;
        int         kind;
        logic [7:0] pool[$];
        logic [7:0] id;
        kind = $urandom_range(0, 99);
        if (kind < 3)       len = $urandom_range(120, 140);
        else if (kind < 15) len = $urandom_range(25, 64);
        else                len = $urandom_range(1, 24);
        pool_n = $urandom_range(1, 24);
        for (int k = 0; k < pool_n; k++) pool.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) id = 8'($urandom_range(0, 255));
            else id = pool[$urandom_range(0, pool_n - 1)];
            send_beat(id, k == len - 1, -1);
        end
    endtask

    task automatic random_phase(input int s_idle, input int r_idle);
        logic [ffe_pkg::CFG_W-1:0] value;
        int                        target;
        send_idle = s_idle;
        recv_idle = r_idle;
        target    = beats_sent + SEND_PER_PHASE;
        while (beats_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0:       value = 5'd0;
                    1:       value = 5'd1;
                    2:       value = 5'd16;
                    3:       value = 5'd31;
                    default: value = ffe_pkg::CFG_W'($urandom_range(0, 31));
                endcase
                write_slot_count(value);
            end
            random_sequence();
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_evictions.size() == 0) begin
                $error("eviction_count beat with nothing expected: got %0d", m_tdata);
                errors++;
            end else begin
                if (m_tdata !== expected_evictions[0]) begin
                    $error("eviction_count mismatch: expected %0d, got %0d",
                           expected_evictions[0], m_tdata);
                    errors++;
                end
                void'(expected_evictions.pop_front());
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].wr_cfg) write_slot_count(directed_rows[r].cfg);
            send_beat(directed_rows[r].id, directed_rows[r].last, directed_rows[r].known);
        end

        random_phase(22, 56);
        random_phase(56, 22);
        random_phase(0, 0);

        s_tvalid <= 1'b0;
        while (expected_evictions.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (errors == 0 && expected_evictions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
